>>> hdl/rfsff_pkg.sv
// ----------------------------------------------------------------------------
// rfsff_pkg
// Shared constants and types for the ring FIFO sync frame finder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfsff_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'hBB;
  localparam logic [7:0] FLAG_BYTE   = 8'h01;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_SCAN  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Per-cycle command to every cell of the byte chain
  typedef struct packed {
    logic push;   // load the push byte into the cell at the fill position
    logic shift;  // every cell takes its upper neighbor
    logic wrap;   // cell at fill-1 takes cell 0 instead (rotate held bytes)
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/rfsff_cell.sv
// ----------------------------------------------------------------------------
// rfsff_cell
// One byte cell of the chain: load on push, shift down or rotate on command.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsff_cell #(
  parameter int DEPTH = rfsff_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  wire logic                         clk,
  input  wire rfsff_pkg::cell_ctrl_t        ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]   count,
  input  wire logic [7:0]                   push_byte,
  input  wire logic [7:0]                   up_byte,
  input  wire logic [7:0]                   head_byte,
  output logic      [7:0]                   byte_val
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] POS = CW'(IDX);

  logic is_tail;
  logic is_last;

  assign is_tail = (POS == count);
  assign is_last = ((POS + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (ctrl.push && is_tail) begin
      byte_val <= push_byte;
    end else if (ctrl.shift) begin
      // close the ring at the newest held byte
      byte_val <= (ctrl.wrap && is_last) ? head_byte : up_byte;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rfsff_chain.sv
// ----------------------------------------------------------------------------
// rfsff_chain
// Row of byte cells, oldest byte in cell 0, with the sync window at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsff_chain #(
  parameter int DEPTH = rfsff_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire rfsff_pkg::cell_ctrl_t        ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]   count,
  input  wire logic [7:0]                   push_byte,
  output logic                              win_sync,
  output logic      [7:0]                   win_first,
  output logic      [7:0]                   win_second
);

  logic [7:0] cells [DEPTH];
  logic [7:0] ups   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign ups[i] = cells[i];
    end else begin : g_mid
      assign ups[i] = cells[i+1];
    end

    rfsff_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .push_byte (push_byte),
      .up_byte   (ups[i]),
      .head_byte (cells[0]),
      .byte_val  (cells[i])
    );
  end

  // sync pair in cells 0 and 1, data bytes in cells 2 and 3
  assign win_sync   = (cells[0] == rfsff_pkg::SYNC_FIRST) &&
                      (cells[1] == rfsff_pkg::SYNC_SECOND);
  assign win_first  = cells[2];
  assign win_second = cells[3];

endmodule

`default_nettype wire

>>> hdl/ring_fifo_sync_frame_finder.sv
// ----------------------------------------------------------------------------
// ring_fifo_sync_frame_finder
// Byte FIFO with push, pop, clear and a search for the latest AA BB frame.
// ----------------------------------------------------------------------------
// The FIFO is a row of DEPTH byte cells with the oldest byte in cell 0. Items
// are taken one at a time. Push, pop and clear pass through the done state,
// which registers their result. A scan rotates the held bytes through a fixed
// four-byte window at cell 0, one position per cycle, then rotates on until
// the byte after the newest frame's 0xBB sits in cell 0, or until the order is
// restored when no frame is found; a scan with fewer than four bytes held goes
// straight to the done state. The input is taken again as soon as a result is
// written to the output register, even while that result still waits.
`default_nettype none

module ring_fifo_sync_frame_finder #(
  parameter int DEPTH = rfsff_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic [7:0]                   data_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              ok,
  output logic      [$clog2(DEPTH+1)-1:0]   fill_count,
  output logic                              is_empty,
  output logic                              is_full,
  output logic                              frame_found,
  output logic      [7:0]                   first_data,
  output logic      [8:0]                   second_value,
  output logic      [$clog2(DEPTH)-1:0]     sync_offset
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int KW = $clog2(DEPTH);
  localparam int RW = $clog2(2*DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ALIGN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                 state;
  rfsff_pkg::op_t         op_q;
  logic [7:0]             byte_q;
  logic [CW-1:0]          count;
  logic [RW-1:0]          rot;
  logic [RW-1:0]          tgt;
  logic                   s_found;
  logic [KW-1:0]          s_k;
  logic [7:0]             s_first;
  logic [7:0]             s_second;

  rfsff_pkg::cell_ctrl_t  ctrl;
  logic                   out_free;
  logic                   win_sync;
  logic [7:0]             win_first;
  logic [7:0]             win_second;
  logic                   last_chk;
  logic [KW-1:0]          k_now;
  logic [RW-1:0]          rot_next;

  assign in_stall   = (state != ST_IDLE);
  assign fill_count = count;
  assign is_empty   = (count == '0);
  assign is_full    = (count == CW'(DEPTH));
  assign out_free   = !out_valid || !out_stall;
  assign rot_next   = rot + RW'(1);
  assign last_chk   = (rot == (RW'(count) - RW'(4)));
  assign k_now      = KW'(rot_next);

  always_comb begin
    ctrl = '0;
    case (state)
      ST_SCAN, ST_ALIGN: begin
        ctrl.shift = 1'b1;
        ctrl.wrap  = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          if (op_q == rfsff_pkg::OP_PUSH && !is_full) begin
            ctrl.push = 1'b1;
          end else if (op_q == rfsff_pkg::OP_POP && !is_empty) begin
            ctrl.shift = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  rfsff_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .count      (count),
    .push_byte  (byte_q),
    .win_sync   (win_sync),
    .win_first  (win_first),
    .win_second (win_second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      count        <= '0;
      rot          <= '0;
      s_found      <= 1'b0;
      frame_found  <= 1'b0;
      first_data   <= '0;
      second_value <= '0;
      sync_offset  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q    <= rfsff_pkg::op_t'(op);
            byte_q  <= data_byte;
            s_found <= 1'b0;
            rot     <= '0;
            if (rfsff_pkg::op_t'(op) == rfsff_pkg::OP_SCAN && count >= CW'(4)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          // keep the last hit: later window positions are newer frames
          if (win_sync) begin
            s_found  <= 1'b1;
            s_k      <= k_now;
            s_first  <= win_first;
            s_second <= win_second;
          end
          rot <= rot_next;
          if (last_chk) begin
            if (win_sync) begin
              tgt <= RW'(count) + RW'(k_now) + RW'(1);
            end else if (s_found) begin
              tgt <= RW'(count) + RW'(s_k) + RW'(1);
            end else begin
              tgt <= RW'(count);
            end
            state <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          // rotate on until the byte after the 0xBB sits in cell 0
          rot <= rot_next;
          if (rot_next == tgt) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
            case (op_q)
              rfsff_pkg::OP_PUSH: begin
                ok <= !is_full;
                if (!is_full) begin
                  count <= count + CW'(1);
                end
              end
              rfsff_pkg::OP_POP: begin
                ok <= !is_empty;
                if (!is_empty) begin
                  count <= count - CW'(1);
                end
              end
              rfsff_pkg::OP_SCAN: begin
                ok          <= s_found;
                frame_found <= s_found;
                if (s_found) begin
                  count        <= count - CW'(s_k) - CW'(1);
                  first_data   <= s_first;
                  second_value <= {(s_first == rfsff_pkg::FLAG_BYTE), s_second};
                  sync_offset  <= s_k;
                end else begin
                  first_data   <= '0;
                  second_value <= '0;
                  sync_offset  <= '0;
                end
              end
              default: begin
                ok           <= 1'b1;
                count        <= '0;
                frame_found  <= 1'b0;
                first_data   <= '0;
                second_value <= '0;
                sync_offset  <= '0;
              end
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ST_IDLE)
    else $error("item taken but control stayed idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_found_offset: assert property (@(posedge clk) disable iff (rst)
    frame_found |-> sync_offset != '0)
    else $error("frame held with zero sync offset");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    !frame_found |-> first_data == '0 && second_value == '0 && sync_offset == '0)
    else $error("frame values held without a frame");

  a_align_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ALIGN |-> rot < tgt)
    else $error("rotation ran past its target");

  a_count_stable_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN || state == ST_ALIGN |=> $stable(count))
    else $error("fill count moved during a scan");

endmodule

`default_nettype wire
